### rtl/core/bsc_pkg.sv
package bsc_pkg;

  // Mouse event codes
  typedef enum logic [1:0] {
    CMD_MOVE_X = 2'd0,
    CMD_MOVE_Y = 2'd1,
    CMD_LEFT   = 2'd2,
    CMD_RIGHT  = 2'd3
  } cmd_t;

  // Sequencer states
  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_RUN
  } state_t;

  // Which cell the address stage is working on
  typedef enum logic [2:0] {
    PH_STAMP,
    PH_CUR,
    PH_PREV,
    PH_NEW,
    PH_DONE
  } phase_t;

  localparam int COORD_W = 6;
  localparam int GRAY_W  = 3;
  localparam int DELTA_W = 4;

  localparam logic [1:0] OVL_PLAIN = 2'd0;
  localparam logic [1:0] OVL_PAINT = 2'd1;
  localparam logic [1:0] OVL_ERASE = 2'd2;
  localparam logic [1:0] OVL_MOVED = 2'd3;

  localparam logic signed [DELTA_W-1:0] DELTA_PAINT_CENTER = 4'sd5;
  localparam logic signed [DELTA_W-1:0] DELTA_ERASE_CENTER = -4'sd7;
  localparam logic signed [DELTA_W-1:0] DELTA_PAINT_ORTHO  = 4'sd2;
  localparam logic signed [DELTA_W-1:0] DELTA_ERASE_ORTHO  = -4'sd2;
  localparam logic signed [DELTA_W-1:0] DELTA_PAINT_OTHER  = 4'sd1;
  localparam logic signed [DELTA_W-1:0] DELTA_ERASE_OTHER  = -4'sd1;

  localparam logic [GRAY_W-1:0] GRAY_MAX = 3'd7;

endpackage

### rtl/core/bsc_ram.sv
module bsc_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 784
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read data holds while rd_en is low
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/core/brush_stamp_canvas_core.sv
// Channel | Direction | Handshake            | Beat payload
// --------+-----------+----------------------+----------------------------------------------
// in_     | input     | in_valid / in_ready  | in_cmd, in_amount
// out_    | output    | out_valid / out_ready| out_cell_x, out_cell_y, out_gray_level,
//         |           |                      | out_overlay, out_last
// cfg_    | input     | cfg_valid / cfg_ready| cfg_brush_radius
//
// After reset the canvas RAM is swept to zero, one cell per cycle;
// in_ready stays low during the sweep, cfg_ready is always high.
// An event is accepted, then the address stage steps through every brush position, (2r+1)^2 with
// clipped positions included, then through one to three cursor cells, and the pipeline drains.
// The single RAM read/write port pair serves both stages.
// A low out_ready stalls the data stage; the address stage holds behind it.

module brush_stamp_canvas_core #(
  parameter int GRID       = 28,
  parameter int MAX_RADIUS = 3
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // event input
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_cmd,
  input  logic signed [7:0]                   in_amount,
  // cell output
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [bsc_pkg::COORD_W-1:0]         out_cell_x,
  output logic [bsc_pkg::COORD_W-1:0]         out_cell_y,
  output logic [bsc_pkg::GRAY_W-1:0]          out_gray_level,
  output logic [1:0]                          out_overlay,
  output logic                                out_last,
  // configuration
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [1:0]                          cfg_brush_radius
);

  localparam int DEPTH  = GRID * GRID;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CW     = bsc_pkg::COORD_W;
  localparam int GW     = bsc_pkg::GRAY_W;
  localparam int DW     = bsc_pkg::DELTA_W;

  localparam logic [CW-1:0]     GRID_MAX  = CW'(GRID - 1);
  localparam logic [CW-1:0]     GRID_HALF = CW'(GRID / 2);
  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(DEPTH - 1);
  localparam logic [1:0]        RAD_MAX   = 2'(MAX_RADIUS);

  // ---------------------------------------------------------------------------
  // State registers
  // ---------------------------------------------------------------------------
  bsc_pkg::state_t state_r, state_nxt;
  bsc_pkg::phase_t phase_r, phase_nxt;

  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;

  logic [CW-1:0] col_r, col_nxt;
  logic [CW-1:0] row_r, row_nxt;
  logic [CW-1:0] prev_col_r, prev_col_nxt;
  logic [CW-1:0] prev_row_r, prev_row_nxt;
  logic          painting_r, painting_nxt;
  logic          erasing_r, erasing_nxt;
  logic          paint_mode_r, paint_mode_nxt;
  logic          moved_r, moved_nxt;
  logic [1:0]    radius_r, radius_nxt;

  // brush offsets of the address stage
  logic signed [2:0] di_r, di_nxt;
  logic signed [2:0] dj_r, dj_nxt;

  // data stage: RAM data arrives here in the cycle after the read
  logic                 b_valid_r, b_valid_nxt;
  logic [ADDR_W-1:0]    b_addr_r, b_addr_nxt;
  logic [CW-1:0]        b_x_r, b_x_nxt;
  logic [CW-1:0]        b_y_r, b_y_nxt;
  logic signed [DW-1:0] b_delta_r, b_delta_nxt;
  logic                 b_write_r, b_write_nxt;
  logic [1:0]           b_ov_r, b_ov_nxt;
  logic                 b_last_r, b_last_nxt;

  // read-during-write bypass
  logic          fwd_r, fwd_nxt;
  logic [GW-1:0] fwd_data_r, fwd_data_nxt;

  // output register
  logic          out_valid_r, out_valid_nxt;
  logic [CW-1:0] out_x_r, out_x_nxt;
  logic [CW-1:0] out_y_r, out_y_nxt;
  logic [GW-1:0] out_gray_r, out_gray_nxt;
  logic [1:0]    out_ov_r, out_ov_nxt;
  logic          out_last_r, out_last_nxt;

  // ---------------------------------------------------------------------------
  // RAM
  // ---------------------------------------------------------------------------
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [GW-1:0]     wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [GW-1:0]     rd_data;

  bsc_ram #(
    .WIDTH (GW),
    .DEPTH (DEPTH)
  ) u_canvas (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // ---------------------------------------------------------------------------
  // Event decode: cursor step with clamp, button flags
  // ---------------------------------------------------------------------------
  logic          amt_pos;
  logic          amt_neg;
  logic          amt_nz;
  logic [CW-1:0] ev_col;
  logic [CW-1:0] ev_row;
  logic          ev_paint;
  logic          ev_erase;
  logic          ev_moved;

  assign amt_nz  = (in_amount != 8'sd0);
  assign amt_neg = in_amount[7];
  assign amt_pos = amt_nz && !amt_neg;

  always_comb begin
    ev_col   = col_r;
    ev_row   = row_r;
    ev_paint = painting_r;
    ev_erase = erasing_r;
    case (bsc_pkg::cmd_t'(in_cmd))
      bsc_pkg::CMD_MOVE_X: begin
        if (amt_pos && col_r != GRID_MAX) begin
          ev_col = col_r + CW'(1);
        end else if (amt_neg && col_r != '0) begin
          ev_col = col_r - CW'(1);
        end
      end
      bsc_pkg::CMD_MOVE_Y: begin
        if (amt_pos && row_r != GRID_MAX) begin
          ev_row = row_r + CW'(1);
        end else if (amt_neg && row_r != '0) begin
          ev_row = row_r - CW'(1);
        end
      end
      bsc_pkg::CMD_LEFT:  ev_paint = amt_nz;
      bsc_pkg::CMD_RIGHT: ev_erase = amt_nz;
      default: ;
    endcase
    ev_moved = (ev_col != col_r) || (ev_row != row_r);
  end

  // ---------------------------------------------------------------------------
  // Address stage: pick the cell for the current phase
  // ---------------------------------------------------------------------------
  logic [1:0]           rad;
  logic signed [2:0]    rad_s;
  logic signed [7:0]    sx;
  logic signed [7:0]    sy;
  logic                 a_in_grid;
  logic [CW-1:0]        a_x;
  logic [CW-1:0]        a_y;
  logic [ADDR_W-1:0]    a_addr;
  logic signed [DW-1:0] a_delta;
  logic                 a_write;
  logic [1:0]           a_ov;
  logic                 a_last;
  logic                 di_zero, dj_zero, di_one, dj_one;

  // radius above what the brush supports saturates
  assign rad   = (radius_r > RAD_MAX) ? RAD_MAX : radius_r;
  assign rad_s = $signed({1'b0, rad});

  assign sx = $signed({2'b00, col_r}) + $signed({{5{di_r[2]}}, di_r});
  assign sy = $signed({2'b00, row_r}) + $signed({{5{dj_r[2]}}, dj_r});

  assign di_zero = (di_r == 3'sd0);
  assign dj_zero = (dj_r == 3'sd0);
  assign di_one  = (di_r == 3'sd1) || (di_r == -3'sd1);
  assign dj_one  = (dj_r == 3'sd1) || (dj_r == -3'sd1);

  always_comb begin
    a_x       = col_r;
    a_y       = row_r;
    a_in_grid = 1'b1;
    a_write   = 1'b0;
    a_ov      = bsc_pkg::OVL_PLAIN;
    a_last    = 1'b0;
    a_delta   = paint_mode_r ? bsc_pkg::DELTA_PAINT_OTHER : bsc_pkg::DELTA_ERASE_OTHER;
    if (di_zero && dj_zero) begin
      a_delta = paint_mode_r ? bsc_pkg::DELTA_PAINT_CENTER : bsc_pkg::DELTA_ERASE_CENTER;
    end else if ((di_zero && dj_one) || (dj_zero && di_one)) begin
      a_delta = paint_mode_r ? bsc_pkg::DELTA_PAINT_ORTHO : bsc_pkg::DELTA_ERASE_ORTHO;
    end
    case (phase_r)
      bsc_pkg::PH_STAMP: begin
        a_x       = sx[CW-1:0];
        a_y       = sy[CW-1:0];
        a_write   = 1'b1;
        a_in_grid = !sx[7] && (sx[6:0] < 7'(GRID)) && !sy[7] && (sy[6:0] < 7'(GRID));
      end
      bsc_pkg::PH_CUR: begin
        a_ov   = paint_mode_r ? bsc_pkg::OVL_PAINT : bsc_pkg::OVL_ERASE;
        a_last = !moved_r;
      end
      bsc_pkg::PH_PREV: begin
        a_x = prev_col_r;
        a_y = prev_row_r;
      end
      bsc_pkg::PH_NEW: begin
        a_ov   = bsc_pkg::OVL_MOVED;
        a_last = 1'b1;
      end
      default: ;
    endcase
    a_addr = ADDR_W'(a_y) * ADDR_W'(GRID) + ADDR_W'(a_x);
  end

  // ---------------------------------------------------------------------------
  // Data stage: saturating update
  // ---------------------------------------------------------------------------
  logic [GW-1:0]     b_data;
  logic signed [4:0] b_sum;
  logic [GW-1:0]     b_sat;
  logic              out_free;
  logic              b_adv;
  logic              b_free;

  assign b_data = fwd_r ? fwd_data_r : rd_data;
  assign b_sum  = $signed({2'b00, b_data}) + $signed({b_delta_r[DW-1], b_delta_r});

  always_comb begin
    if (b_sum[4]) begin
      b_sat = '0;
    end else if (b_sum[3]) begin
      b_sat = bsc_pkg::GRAY_MAX;
    end else begin
      b_sat = b_sum[GW-1:0];
    end
  end

  assign out_free = !out_valid_r || out_ready;
  assign b_adv    = b_valid_r && out_free;
  assign b_free   = !b_valid_r || b_adv;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    clr_addr_nxt   = clr_addr_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    prev_col_nxt   = prev_col_r;
    prev_row_nxt   = prev_row_r;
    painting_nxt   = painting_r;
    erasing_nxt    = erasing_r;
    paint_mode_nxt = paint_mode_r;
    moved_nxt      = moved_r;
    radius_nxt     = radius_r;
    di_nxt         = di_r;
    dj_nxt         = dj_r;
    b_valid_nxt    = b_valid_r;
    b_addr_nxt     = b_addr_r;
    b_x_nxt        = b_x_r;
    b_y_nxt        = b_y_r;
    b_delta_nxt    = b_delta_r;
    b_write_nxt    = b_write_r;
    b_ov_nxt       = b_ov_r;
    b_last_nxt     = b_last_r;
    fwd_nxt        = fwd_r;
    fwd_data_nxt   = fwd_data_r;
    out_valid_nxt  = out_valid_r;
    out_x_nxt      = out_x_r;
    out_y_nxt      = out_y_r;
    out_gray_nxt   = out_gray_r;
    out_ov_nxt     = out_ov_r;
    out_last_nxt   = out_last_r;
    in_ready       = 1'b0;
    wr_en          = 1'b0;
    wr_addr        = b_addr_r;
    wr_data        = b_sat;
    rd_en          = 1'b0;
    rd_addr        = a_addr;

    // take the register write at any time; the block is idle by contract
    if (cfg_valid) begin
      radius_nxt = cfg_brush_radius;
    end

    // drop the output beat once taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      bsc_pkg::S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr_r;
        wr_data = '0;
        if (clr_addr_r == ADDR_LAST) begin
          state_nxt = bsc_pkg::S_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + ADDR_W'(1);
        end
      end

      bsc_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          col_nxt        = ev_col;
          row_nxt        = ev_row;
          prev_col_nxt   = col_r;
          prev_row_nxt   = row_r;
          painting_nxt   = ev_paint;
          erasing_nxt    = ev_erase;
          paint_mode_nxt = ev_paint;
          moved_nxt      = ev_moved;
          di_nxt         = -rad_s;
          dj_nxt         = -rad_s;
          if (ev_paint || ev_erase) begin
            phase_nxt = bsc_pkg::PH_STAMP;
            state_nxt = bsc_pkg::S_RUN;
          end else if (ev_moved) begin
            phase_nxt = bsc_pkg::PH_PREV;
            state_nxt = bsc_pkg::S_RUN;
          end
        end
      end

      bsc_pkg::S_RUN: begin
        // retire the data-stage cell into the output register
        if (b_adv) begin
          b_valid_nxt   = 1'b0;
          wr_en         = b_write_r;
          out_valid_nxt = 1'b1;
          out_x_nxt     = b_x_r;
          out_y_nxt     = b_y_r;
          out_gray_nxt  = b_write_r ? b_sat : b_data;
          out_ov_nxt    = b_ov_r;
          out_last_nxt  = b_last_r;
        end

        // advance the address stage when the data stage has room
        if (phase_r != bsc_pkg::PH_DONE && b_free) begin
          if (a_in_grid) begin
            rd_en        = 1'b1;
            fwd_nxt      = wr_en && (wr_addr == a_addr);
            fwd_data_nxt = wr_data;
            b_valid_nxt  = 1'b1;
            b_addr_nxt   = a_addr;
            b_x_nxt      = a_x;
            b_y_nxt      = a_y;
            b_delta_nxt  = a_delta;
            b_write_nxt  = a_write;
            b_ov_nxt     = a_ov;
            b_last_nxt   = a_last;
          end
          case (phase_r)
            bsc_pkg::PH_STAMP: begin
              if (dj_r == rad_s) begin
                if (di_r == rad_s) begin
                  phase_nxt = bsc_pkg::PH_CUR;
                end else begin
                  di_nxt = di_r + 3'sd1;
                  dj_nxt = -rad_s;
                end
              end else begin
                dj_nxt = dj_r + 3'sd1;
              end
            end
            bsc_pkg::PH_CUR:  phase_nxt = moved_r ? bsc_pkg::PH_PREV : bsc_pkg::PH_DONE;
            bsc_pkg::PH_PREV: phase_nxt = bsc_pkg::PH_NEW;
            default:          phase_nxt = bsc_pkg::PH_DONE;
          endcase
        end

        if (phase_r == bsc_pkg::PH_DONE && !b_valid_r) begin
          state_nxt = bsc_pkg::S_IDLE;
        end
      end

      default: state_nxt = bsc_pkg::S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= bsc_pkg::S_CLEAR;
      phase_r      <= bsc_pkg::PH_DONE;
      clr_addr_r   <= '0;
      col_r        <= GRID_HALF;
      row_r        <= GRID_HALF;
      prev_col_r   <= GRID_HALF;
      prev_row_r   <= GRID_HALF;
      painting_r   <= 1'b0;
      erasing_r    <= 1'b0;
      paint_mode_r <= 1'b0;
      moved_r      <= 1'b0;
      radius_r     <= 2'd3;
      b_valid_r    <= 1'b0;
      fwd_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      phase_r      <= phase_nxt;
      clr_addr_r   <= clr_addr_nxt;
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      prev_col_r   <= prev_col_nxt;
      prev_row_r   <= prev_row_nxt;
      painting_r   <= painting_nxt;
      erasing_r    <= erasing_nxt;
      paint_mode_r <= paint_mode_nxt;
      moved_r      <= moved_nxt;
      radius_r     <= radius_nxt;
      b_valid_r    <= b_valid_nxt;
      fwd_r        <= fwd_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    di_r       <= di_nxt;
    dj_r       <= dj_nxt;
    b_addr_r   <= b_addr_nxt;
    b_x_r      <= b_x_nxt;
    b_y_r      <= b_y_nxt;
    b_delta_r  <= b_delta_nxt;
    b_write_r  <= b_write_nxt;
    b_ov_r     <= b_ov_nxt;
    b_last_r   <= b_last_nxt;
    fwd_data_r <= fwd_data_nxt;
    out_x_r    <= out_x_nxt;
    out_y_r    <= out_y_nxt;
    out_gray_r <= out_gray_nxt;
    out_ov_r   <= out_ov_nxt;
    out_last_r <= out_last_nxt;
  end

  assign cfg_ready      = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_cell_x     = out_x_r;
  assign out_cell_y     = out_y_r;
  assign out_gray_level = out_gray_r;
  assign out_overlay    = out_ov_r;
  assign out_last       = out_last_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_cursor_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    (col_r <= GRID_MAX) && (row_r <= GRID_MAX))
    else $error("cursor left the grid");

  a_no_output_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bsc_pkg::S_CLEAR) |-> (!out_valid_r && !b_valid_r))
    else $error("cell beat during clearing sweep");

  a_accept_stage_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> !b_valid_r)
    else $error("event accepted with data stage busy");

  a_last_closes_event: assert property (@(posedge clk) disable iff (!rst_n)
    (b_adv && b_last_r) |-> (phase_r == bsc_pkg::PH_DONE))
    else $error("last beat retired while cells still pending");

  a_data_stage_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid_r |-> ((b_x_r <= GRID_MAX) && (b_y_r <= GRID_MAX)))
    else $error("clipped cell reached the data stage");

endmodule

### tb/sv/tb_brush_stamp_canvas_core.sv
module tb_brush_stamp_canvas_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GRID       = 28;
  localparam int MAX_RADIUS = 3;

  // Settle time after the last expected beat: one full event with headroom.
  localparam int DRAIN_CYCLES = 80;
  // Quiet cycles tolerated before giving up.
  localparam int QUIET_LIMIT  = 4000;
  localparam int RANDOM_PER_RADIUS = 31;

  typedef struct packed {
    logic [bsc_pkg::COORD_W-1:0] x;
    logic [bsc_pkg::COORD_W-1:0] y;
    logic [bsc_pkg::GRAY_W-1:0]  gray;
    logic [1:0]                  ovl;
    logic                        last;
  } cell_beat_t;

  // One row of the directed script. Rows marked pinned carry the beat count and
  // the final beat as they read straight off the stamping rules.
  typedef struct {
    bsc_pkg::cmd_t               cmd;
    logic signed [7:0]           amt;
    int                          reps;
    bit                          pinned;
    int                          n_cells;
    logic [bsc_pkg::COORD_W-1:0] x;
    logic [bsc_pkg::COORD_W-1:0] y;
    logic [bsc_pkg::GRAY_W-1:0]  gray;
    logic [1:0]                  ovl;
  } script_row_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [1:0]                  in_cmd = bsc_pkg::CMD_MOVE_X;
  logic signed [7:0]           in_amount = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [bsc_pkg::COORD_W-1:0] out_cell_x;
  logic [bsc_pkg::COORD_W-1:0] out_cell_y;
  logic [bsc_pkg::GRAY_W-1:0]  out_gray_level;
  logic [1:0]                  out_overlay;
  logic                        out_last;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [1:0]                  cfg_brush_radius = 2'd0;

  brush_stamp_canvas_core #(
    .GRID      (GRID),
    .MAX_RADIUS(MAX_RADIUS)
  ) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_amount       (in_amount),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_cell_x      (out_cell_x),
    .out_cell_y      (out_cell_y),
    .out_gray_level  (out_gray_level),
    .out_overlay     (out_overlay),
    .out_last        (out_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_brush_radius(cfg_brush_radius)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow canvas: our own copy of the painter state, advanced on every
  // accepted event beat.
  // ---------------------------------------------------------------------------
  logic [bsc_pkg::GRAY_W-1:0] shadow_canvas [GRID*GRID];
  int                         pen_col;
  int                         pen_row;
  bit                         paint_on;
  bit                         erase_on;
  logic [1:0]                 radius_set;

  // Cells the block still owes us, oldest first.
  cell_beat_t        pending_cells [$];

  int error_count   = 0;
  int events_sent   = 0;
  int beats_checked = 0;
  int burst_left    = 0;
  int quiet_cycles  = 0;

  function automatic void push_cell(int x, int y, logic [1:0] ovl);
    cell_beat_t c;
    c.x    = bsc_pkg::COORD_W'(x);
    c.y    = bsc_pkg::COORD_W'(y);
    c.gray = shadow_canvas[y*GRID + x];
    c.ovl  = ovl;
    c.last = 1'b0;
    pending_cells.push_back(c);
  endfunction

  // Apply one mouse event to the shadow canvas and queue the cells it updates.
  // Return how many cell beats it produces.
  function automatic int apply_event(bsc_pkg::cmd_t c, logic signed [7:0] a);
    int  prev_col;
    int  prev_row;
    int  n;
    int  rad;
    int  x;
    int  y;
    int  d;
    int  v;
    bit  add;
    prev_col = pen_col;
    prev_row = pen_row;
    n = 0;
    case (c)
      bsc_pkg::CMD_MOVE_X: begin
        if (a > 0) pen_col++;
        else if (a < 0) pen_col--;
      end
      bsc_pkg::CMD_MOVE_Y: begin
        if (a > 0) pen_row++;
        else if (a < 0) pen_row--;
      end
      bsc_pkg::CMD_LEFT:  paint_on = (a != 0);
      default:            erase_on = (a != 0);
    endcase
    // Clamp to the grid; a move into an edge is no move at all.
    if (pen_col < 0) pen_col = 0;
    if (pen_col >= GRID) pen_col = GRID - 1;
    if (pen_row < 0) pen_row = 0;
    if (pen_row >= GRID) pen_row = GRID - 1;

    // Paint wins over erase when both buttons are held.
    if (paint_on || erase_on) begin
      add = paint_on;
      rad = (int'(radius_set) > MAX_RADIUS) ? MAX_RADIUS : int'(radius_set);
      for (int di = -rad; di <= rad; di++) begin
        for (int dj = -rad; dj <= rad; dj++) begin
          x = pen_col + di;
          y = pen_row + dj;
          if (x < 0 || x >= GRID || y < 0 || y >= GRID) continue;
          if (di == 0 && dj == 0)
            d = add ? int'(bsc_pkg::DELTA_PAINT_CENTER) : int'(bsc_pkg::DELTA_ERASE_CENTER);
          else if ((di == 0 && (dj == 1 || dj == -1)) ||
                   (dj == 0 && (di == 1 || di == -1)))
            d = add ? int'(bsc_pkg::DELTA_PAINT_ORTHO) : int'(bsc_pkg::DELTA_ERASE_ORTHO);
          else
            d = add ? int'(bsc_pkg::DELTA_PAINT_OTHER) : int'(bsc_pkg::DELTA_ERASE_OTHER);
          v = int'(shadow_canvas[y*GRID + x]) + d;
          if (v > int'(bsc_pkg::GRAY_MAX)) v = int'(bsc_pkg::GRAY_MAX);
          if (v < 0) v = 0;
          shadow_canvas[y*GRID + x] = bsc_pkg::GRAY_W'(v);
          push_cell(x, y, bsc_pkg::OVL_PLAIN);
          n++;
        end
      end
      push_cell(pen_col, pen_row, add ? bsc_pkg::OVL_PAINT : bsc_pkg::OVL_ERASE);
      n++;
    end

    // Restore the old cursor cell, then show the new one.
    if (pen_col != prev_col || pen_row != prev_row) begin
      push_cell(prev_col, prev_row, bsc_pkg::OVL_PLAIN);
      push_cell(pen_col, pen_row, bsc_pkg::OVL_MOVED);
      n += 2;
    end

    if (n > 0) pending_cells[pending_cells.size()-1].last = 1'b1;
    return n;
  endfunction

  // ---------------------------------------------------------------------------
  // Event sender: bursts of back-to-back beats separated by random gaps.
  // Drive at the falling edge, detect the accept at the rising edge.
  // ---------------------------------------------------------------------------
  task automatic send_event(input bsc_pkg::cmd_t c, input logic signed [7:0] a,
                            output int n_cells);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      // Mostly short gaps; every so often a long gap-free burst.
      if ($urandom_range(0, 5) == 0) begin
        gap = 0;
        burst_left = $urandom_range(20, 40);
      end else begin
        gap = $urandom_range(0, 25);
        burst_left = $urandom_range(1, 10);
      end
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_valid  = 1'b1;
    in_cmd    = c;
    in_amount = a;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    events_sent++;
    n_cells = apply_event(c, a);
  endtask

  // Let the block drain: drop valid, wait out every owed beat, then give an
  // event that owes nothing time to finish before touching the register.
  task automatic drain_block();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_cells.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_radius(input logic [1:0] r);
    @(negedge clk);
    cfg_valid        = 1'b1;
    cfg_brush_radius = r;
    do @(posedge clk); while (!cfg_ready);
    radius_set = r;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: alternate ready runs and stall runs of random length, with the
  // odd long run of no stalls at all.
  // ---------------------------------------------------------------------------
  int stall_run = 0;

  always @(negedge clk) begin
    if (stall_run == 0) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          out_ready = 1'b1;
          stall_run = $urandom_range(1, 30);
        end
        5, 6, 7: begin
          out_ready = 1'b0;
          stall_run = $urandom_range(1, 6);
        end
        8: begin
          out_ready = 1'b0;
          stall_run = $urandom_range(10, 20);
        end
        default: begin
          out_ready = 1'b1;
          stall_run = 150;
        end
      endcase
    end
    stall_run--;
  end

  // ---------------------------------------------------------------------------
  // Cell monitor: compare every accepted out beat with the oldest owed cell.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cell_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_cells.size() == 0) begin
        error_count++;
        $display("%0t: unexpected cell beat, expected none, actual x=%0d y=%0d gray=%0d ovl=%0d last=%0b",
                 $time, out_cell_x, out_cell_y, out_gray_level, out_overlay, out_last);
      end else begin
        want = pending_cells.pop_front();
        beats_checked++;
        if (out_cell_x != want.x || out_cell_y != want.y || out_gray_level != want.gray ||
            out_overlay != want.ovl || out_last != want.last) begin
          error_count++;
          $display("%0t: cell mismatch expected x=%0d y=%0d gray=%0d ovl=%0d last=%0b",
                   $time, want.x, want.y, want.gray, want.ovl, want.last);
          $display("%0t:                 actual x=%0d y=%0d gray=%0d ovl=%0d last=%0b",
                   $time, out_cell_x, out_cell_y, out_gray_level, out_overlay, out_last);
        end
      end
    end
  end

  // Watchdog: count cycles in which no channel moves a beat.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles, %0d cells still owed",
               $time, quiet_cycles, pending_cells.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Directed script
  // ---------------------------------------------------------------------------
  script_row_t script_rows [$];

  function automatic void plan(bsc_pkg::cmd_t c, logic signed [7:0] a, int reps,
                               bit pinned, int n_cells, int x, int y, int gray,
                               logic [1:0] ovl);
    script_row_t r;
    r.cmd     = c;
    r.amt     = a;
    r.reps    = reps;
    r.pinned  = pinned;
    r.n_cells = n_cells;
    r.x       = bsc_pkg::COORD_W'(x);
    r.y       = bsc_pkg::COORD_W'(y);
    r.gray    = bsc_pkg::GRAY_W'(gray);
    r.ovl     = ovl;
    script_rows.push_back(r);
  endfunction

  int radius_plan [5] = '{0, 2, 1, 3, 0};

  initial begin
    int                n_cells;
    cell_beat_t        tail;
    bsc_pkg::cmd_t     c;
    logic signed [7:0] a;
    bit                drift_x;
    bit                drift_y;
    bit                drift;

    for (int i = 0; i < GRID*GRID; i++) shadow_canvas[i] = '0;
    pen_col    = GRID / 2;
    pen_row    = GRID / 2;
    paint_on   = 1'b0;
    erase_on   = 1'b0;
    radius_set = 2'd3;

    // Cursor starts at the grid center on a blank canvas, full-size brush.
    // Step off center, then off and back along Y; try a zero move and the amount extremes.
    plan(bsc_pkg::CMD_MOVE_X, 8'sh01,  1, 1,  2, 15, 14, 0, bsc_pkg::OVL_MOVED);
    plan(bsc_pkg::CMD_MOVE_X, 8'sh00,  1, 1,  0,  0,  0, 0, bsc_pkg::OVL_PLAIN);
    plan(bsc_pkg::CMD_MOVE_Y, 8'sh80,  1, 1,  2, 15, 13, 0, bsc_pkg::OVL_MOVED);
    plan(bsc_pkg::CMD_MOVE_Y, 8'sh7f,  1, 1,  2, 15, 14, 0, bsc_pkg::OVL_MOVED);
    // Press paint twice: center goes to 5 then saturates at 7.
    plan(bsc_pkg::CMD_LEFT,   8'sh01,  1, 1, 50, 15, 14, 5, bsc_pkg::OVL_PAINT);
    plan(bsc_pkg::CMD_LEFT,   8'sh80,  1, 1, 50, 15, 14, 7, bsc_pkg::OVL_PAINT);
    // Hold erase too: paint still wins.
    plan(bsc_pkg::CMD_RIGHT,  8'sh7f,  1, 1, 50, 15, 14, 7, bsc_pkg::OVL_PAINT);
    // Release paint: erase takes over and clears the center.
    plan(bsc_pkg::CMD_LEFT,   8'sh00,  1, 1, 50, 15, 14, 0, bsc_pkg::OVL_ERASE);
    // Move while erasing: full stamp, overlay, old cell, new cursor.
    plan(bsc_pkg::CMD_MOVE_X, 8'sh01,  1, 1, 52, 16, 14, 0, bsc_pkg::OVL_MOVED);
    plan(bsc_pkg::CMD_RIGHT,  8'sh00,  1, 1,  0,  0,  0, 0, bsc_pkg::OVL_PLAIN);
    // Walk to the right edge, then push into it.
    plan(bsc_pkg::CMD_MOVE_X, 8'sh01, 11, 0,  0,  0,  0, 0, bsc_pkg::OVL_PLAIN);
    plan(bsc_pkg::CMD_MOVE_X, 8'sh05,  1, 1,  0,  0,  0, 0, bsc_pkg::OVL_PLAIN);
    // Paint at the edge: brush clipped to 4 columns by 7 rows.
    plan(bsc_pkg::CMD_LEFT,   8'sh01,  1, 1, 29, 27, 14, 5, bsc_pkg::OVL_PAINT);
    plan(bsc_pkg::CMD_MOVE_X, 8'sh01,  1, 1, 29, 27, 14, 7, bsc_pkg::OVL_PAINT);
    plan(bsc_pkg::CMD_LEFT,   8'sh00,  1, 1,  0,  0,  0, 0, bsc_pkg::OVL_PLAIN);

    // Hold reset, then release it at a falling edge.
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    write_radius(2'd3);

    foreach (script_rows[i]) begin
      for (int k = 0; k < script_rows[i].reps; k++) begin
        send_event(script_rows[i].cmd, script_rows[i].amt, n_cells);
        if (script_rows[i].pinned) begin
          tail = (n_cells > 0) ? pending_cells[pending_cells.size()-1] : '0;
          if (n_cells != script_rows[i].n_cells ||
              (n_cells > 0 && (tail.x != script_rows[i].x || tail.y != script_rows[i].y ||
                               tail.gray != script_rows[i].gray ||
                               tail.ovl != script_rows[i].ovl))) begin
            error_count++;
            $display("%0t: script row %0d expected %0d cells ending x=%0d y=%0d gray=%0d ovl=%0d",
                     $time, i, script_rows[i].n_cells, script_rows[i].x, script_rows[i].y,
                     script_rows[i].gray, script_rows[i].ovl);
            $display("%0t: script row %0d shadow gave %0d cells ending",
                     $time, i, n_cells);
            $display("%0t:   x=%0d y=%0d gray=%0d ovl=%0d",
                     $time, tail.x, tail.y, tail.gray, tail.ovl);
          end
        end
      end
    end

    // Random strokes: mostly drifting moves with the odd button press or
    // release, so the cursor sweeps into edges and corners with a brush down.
    drift_x = 1'b0;
    drift_y = 1'b1;
    foreach (radius_plan[p]) begin
      drain_block();
      write_radius(2'(radius_plan[p]));
      for (int k = 0; k < RANDOM_PER_RADIUS; k++) begin
        if ($urandom_range(0, 99) < 8) drift_x = ~drift_x;
        if ($urandom_range(0, 99) < 8) drift_y = ~drift_y;
        if ($urandom_range(0, 99) < 14) begin
          c = $urandom_range(0, 1) ? bsc_pkg::CMD_LEFT : bsc_pkg::CMD_RIGHT;
          a = $urandom_range(0, 1) ? 8'sh00 : 8'($urandom_range(1, 255));
        end else begin
          c = $urandom_range(0, 1) ? bsc_pkg::CMD_MOVE_X : bsc_pkg::CMD_MOVE_Y;
          drift = (c == bsc_pkg::CMD_MOVE_X) ? drift_x : drift_y;
          if ($urandom_range(0, 99) < 15) drift = ~drift;
          a = 8'($urandom_range(1, 127));
          if (!drift) a = ($urandom_range(0, 15) == 0) ? 8'sh80 : -a;
          if ($urandom_range(0, 19) == 0) a = 8'sh00;
        end
        send_event(c, a, n_cells);
      end
    end

    drain_block();

    $display("Sent %0d mouse events (%0d scripted) over brush radii 3, 0, 2, 1, 3, 0;",
             events_sent, 25);
    $display("checked %0d canvas cell beats, %0d errors", beats_checked, error_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
